// ===== rtl/core/bpp_pkg.sv =====
// Package for the relativistic Boris particle push core.
// Holds the word format, the packed stream layout and the saturating fixed-point helpers.
// No dependencies.
package bpp_pkg;

    localparam int WORD_W  = 32;
    localparam int FRAC_W  = 24;
    localparam int PROD_QW = 2 * WORD_W - FRAC_W;
    localparam int SQ_N    = (WORD_W + FRAC_W) / 2;
    localparam int DIV_LAT = WORD_W + 1;
    localparam int IN_W    = 12 * WORD_W;
    localparam int GAMMA_W = WORD_W - 1;
    localparam int OUT_W   = ((6 * WORD_W + GAMMA_W + 7) / 8) * 8;
    localparam int ADDR_W  = 2;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef word_t [2:0] vec3_t;
    typedef logic [PROD_QW-1:0] prod_q_t;

    localparam word_t MAX_POS = {1'b0, {(WORD_W-1){1'b1}}};
    localparam word_t MIN_NEG = {1'b1, {(WORD_W-1){1'b0}}};
    localparam word_t FX_ONE  = word_t'(1 << FRAC_W);
    localparam word_t FX_TWO  = word_t'(2 << FRAC_W);

    localparam logic [ADDR_W-1:0] CFG_HALF_KICK = 2'd0;
    localparam logic [ADDR_W-1:0] CFG_INV_C2    = 2'd1;
    localparam logic [ADDR_W-1:0] CFG_TIME_STEP = 2'd2;

    function automatic logic [WORD_W-1:0] mag(input word_t a);
        logic [WORD_W-1:0] u;
        u = $unsigned(a);
        if (a[WORD_W-1])
        begin
            u = ~u + 1'b1;
        end
        return u;
    endfunction

    function automatic word_t from_mag(input logic neg, input prod_q_t q);
        prod_q_t lim;
        lim = {{(PROD_QW-WORD_W){1'b0}}, MAX_POS};
        if (!neg)
        begin
            return (q > lim) ? MAX_POS : word_t'(q[WORD_W-1:0]);
        end
        return (q > lim) ? MIN_NEG : word_t'(-q[WORD_W-1:0]);
    endfunction

    function automatic word_t fx_mul(input word_t a, input word_t b);
        logic [2*WORD_W-1:0] pr;
        pr = mag(a) * mag(b);
        return from_mag(a[WORD_W-1] ^ b[WORD_W-1], pr[2*WORD_W-1:FRAC_W]);
    endfunction

    function automatic word_t clamp_wide(input logic signed [WORD_W:0] s);
        if (s[WORD_W] != s[WORD_W-1])
        begin
            return s[WORD_W] ? MIN_NEG : MAX_POS;
        end
        return s[WORD_W-1:0];
    endfunction

    function automatic word_t sat_add(input word_t a, input word_t b);
        logic signed [WORD_W:0] s;
        s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        return clamp_wide(s);
    endfunction

    function automatic word_t sat_sub(input word_t a, input word_t b);
        logic signed [WORD_W:0] s;
        s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
        return clamp_wide(s);
    endfunction

    function automatic word_t clamp_pos(input logic [WORD_W+1:0] s);
        return (s > {2'b00, MAX_POS}) ? MAX_POS : word_t'(s[WORD_W-1:0]);
    endfunction

endpackage

// ===== rtl/core/bpp_delay.sv =====
// Payload delay line for the Boris push pipeline.
// A chain of enabled registers; no dependencies.
module bpp_delay #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] line_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            line_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign dout = line_reg[DEPTH-1];

endmodule

// ===== rtl/core/bpp_sqrt.sv =====
// Pipelined fixed-point square root, one root bit per stage.
// Returns floor(sqrt(x << FRAC_W)); depends on bpp_pkg.
module bpp_sqrt (
    input  logic          clk,
    input  logic          en,
    input  bpp_pkg::word_t x,
    output bpp_pkg::word_t root
);
    import bpp_pkg::*;

    localparam int RAD_W = 2 * SQ_N;
    localparam int REM_W = SQ_N + 2;

    logic [REM_W-1:0] rem_reg  [SQ_N];
    logic [SQ_N-1:0]  root_reg [SQ_N];
    logic [RAD_W-1:0] rad_reg  [SQ_N];
    logic [REM_W-1:0] rem_in   [SQ_N];
    logic [SQ_N-1:0]  root_in  [SQ_N];
    logic [RAD_W-1:0] rad_in   [SQ_N];
    logic [WORD_W-1:0] ux;

    assign ux = x[WORD_W-1] ? '0 : $unsigned(x);

    for (genvar s = 0; s < SQ_N; s++)
    begin : g_stage
        logic [REM_W-1:0] rem_shift;
        logic [REM_W-1:0] trial;
        logic             fits;

        if (s == 0)
        begin : g_first
            assign rem_in[s]  = '0;
            assign root_in[s] = '0;
            assign rad_in[s]  = {{(RAD_W-WORD_W-FRAC_W){1'b0}}, ux, {FRAC_W{1'b0}}};
        end
        else
        begin : g_next
            assign rem_in[s]  = rem_reg[s-1];
            assign root_in[s] = root_reg[s-1];
            assign rad_in[s]  = rad_reg[s-1];
        end

        assign rem_shift = {rem_in[s][REM_W-3:0], rad_in[s][RAD_W-1:RAD_W-2]};
        assign trial     = {root_in[s], 2'b01};
        assign fits      = rem_shift >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= fits ? rem_shift - trial : rem_shift;
                root_reg[s] <= {root_in[s][SQ_N-2:0], fits};
                rad_reg[s]  <= {rad_in[s][RAD_W-3:0], 2'b00};
            end
        end
    end

    assign root = word_t'({{(WORD_W-SQ_N){1'b0}}, root_reg[SQ_N-1]});

endmodule

// ===== rtl/core/bpp_div.sv =====
// Pipelined saturating fixed-point divider, one quotient bit per stage plus a clamp stage.
// Computes (num << FRAC_W) / den truncated toward zero; depends on bpp_pkg.
module bpp_div (
    input  logic          clk,
    input  logic          en,
    input  bpp_pkg::word_t num,
    input  bpp_pkg::word_t den,
    output bpp_pkg::word_t quo
);
    import bpp_pkg::*;

    localparam int N  = WORD_W;
    localparam int RW = WORD_W + 1;

    logic [RW-1:0]     r_reg   [N];
    logic [N-1:0]      q_reg   [N];
    logic [N-1:0]      lo_reg  [N];
    logic [WORD_W-1:0] d_reg   [N];
    logic              neg_reg [N];
    logic              bad_reg [N];
    logic [RW-1:0]     r_in    [N];
    logic [N-1:0]      q_in    [N];
    logic [N-1:0]      lo_in   [N];
    logic [WORD_W-1:0] d_in    [N];
    logic              neg_in  [N];
    logic              bad_in  [N];
    logic [WORD_W+FRAC_W-1:0] dvd;
    word_t             quo_reg;

    assign dvd = {mag(num), {FRAC_W{1'b0}}};

    for (genvar s = 0; s < N; s++)
    begin : g_stage
        logic [RW-1:0] r_shift;
        logic          fits;

        if (s == 0)
        begin : g_first
            assign r_in[s]   = {{(RW-FRAC_W){1'b0}}, dvd[WORD_W+FRAC_W-1:WORD_W]};
            assign q_in[s]   = '0;
            assign lo_in[s]  = dvd[WORD_W-1:0];
            assign d_in[s]   = $unsigned(den);
            assign neg_in[s] = num[WORD_W-1];
            assign bad_in[s] = den[WORD_W-1] || (den == '0);
        end
        else
        begin : g_next
            assign r_in[s]   = r_reg[s-1];
            assign q_in[s]   = q_reg[s-1];
            assign lo_in[s]  = lo_reg[s-1];
            assign d_in[s]   = d_reg[s-1];
            assign neg_in[s] = neg_reg[s-1];
            assign bad_in[s] = bad_reg[s-1];
        end

        assign r_shift = {r_in[s][RW-2:0], lo_in[s][N-1]};
        assign fits    = r_shift >= {1'b0, d_in[s]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[s]   <= fits ? r_shift - {1'b0, d_in[s]} : r_shift;
                q_reg[s]   <= {q_in[s][N-2:0], fits};
                lo_reg[s]  <= {lo_in[s][N-2:0], 1'b0};
                d_reg[s]   <= d_in[s];
                neg_reg[s] <= neg_in[s];
                bad_reg[s] <= bad_in[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= bad_reg[N-1] ? '0 :
                from_mag(neg_reg[N-1], {{(PROD_QW-N){1'b0}}, q_reg[N-1]});
        end
    end

    assign quo = quo_reg;

endmodule

// ===== rtl/core/relativistic_boris_particle_push_core.sv =====
// Relativistic Boris particle pusher: one particle per transaction in, one result out.
// The core accepts one particle every clock cycle while the output is not stalled; its
// pipeline is built around the 28-stage square root for gamma followed by two 33-stage dividers
// in series (k/gamma, then 2/(1+|T|^2)), with one multiplier per stage elsewhere. An output
// stall freezes the whole pipeline and holds the input ready low until the result is taken.
// Depends on bpp_pkg, bpp_delay, bpp_sqrt and bpp_div.
module relativistic_boris_particle_push_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [bpp_pkg::ADDR_W-1:0]   cfg_addr,
    input  logic [bpp_pkg::WORD_W-1:0]   cfg_wdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // vel_x, vel_y, vel_z, efield_x..z, bfield_x..z, pos_x..z, 32 bits each from bit 0 up.
    input  logic [bpp_pkg::IN_W-1:0]     s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // new_vel_x..z, new_pos_x..z (32 bits each), lorentz_factor (31 bits), one zero pad bit.
    output logic [bpp_pkg::OUT_W-1:0]    m_tdata
);
    import bpp_pkg::*;

    localparam int ST_G   = 4 + SQ_N;
    localparam int ST_TS  = ST_G + DIV_LAT;
    localparam int ST_T   = ST_TS + 1;
    localparam int ST_DEN = ST_T + 2;
    localparam int ST_SS  = ST_DEN + DIV_LAT;
    localparam int ST_OUT = ST_SS + 6;

    logic              en;
    logic [ST_OUT-1:0] vld_reg;

    word_t             kcoef_reg;
    logic [GAMMA_W-1:0] inv_c2_reg;
    logic [GAMMA_W-1:0] tstep_reg;

    vec3_t u_in, e_in, b_in, p_in;
    vec3_t u_d1, b_d, p_d, vm_d66, vm_d67, vm_d103, ke_d, t_d, v0_d, nv_d;
    word_t gamma, tscale, hscale, sscale, h_d, gamma_d;

    vec3_t uu_reg, ke_reg, vm_reg, t_reg, tt_reg, cp_reg, cq_reg, v0_reg;
    vec3_t s_reg, p2_reg, q2_reg, vp_reg, nv_reg, hn_reg, np_reg, nvo_reg;
    word_t sq_reg, m_reg, g2_reg, den_reg, gout_reg;

    vec3_t uu_next, ke_next, vm_next, t_next, tt_next, cp_next, cq_next, v0_next;
    vec3_t s_next, p2_next, q2_next, vp_next, nv_next, hn_next, np_next;
    word_t sq_next, m_next, g2_next, den_next;

    assign en       = !vld_reg[ST_OUT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[ST_OUT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            kcoef_reg  <= '0;
            inv_c2_reg <= GAMMA_W'(FX_ONE);
            tstep_reg  <= '0;
        end
        else
        begin
            if (en)
            begin
                vld_reg <= {vld_reg[ST_OUT-2:0], s_tvalid};
            end
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_HALF_KICK: kcoef_reg  <= cfg_wdata;
                    CFG_INV_C2:    inv_c2_reg <= cfg_wdata[GAMMA_W-1:0];
                    CFG_TIME_STEP: tstep_reg  <= cfg_wdata[GAMMA_W-1:0];
                    default:       ;
                endcase
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            u_in[i] = s_tdata[i*WORD_W +: WORD_W];
            e_in[i] = s_tdata[(3+i)*WORD_W +: WORD_W];
            b_in[i] = s_tdata[(6+i)*WORD_W +: WORD_W];
            p_in[i] = s_tdata[(9+i)*WORD_W +: WORD_W];
        end
    end

    bpp_delay #(.WIDTH(3*WORD_W), .DEPTH(1)) u_dly_u (
        .clk(clk), .en(en), .din(u_in), .dout(u_d1));
    bpp_delay #(.WIDTH(3*WORD_W), .DEPTH(ST_TS)) u_dly_b (
        .clk(clk), .en(en), .din(b_in), .dout(b_d));
    bpp_delay #(.WIDTH(3*WORD_W), .DEPTH(ST_OUT-1)) u_dly_p (
        .clk(clk), .en(en), .din(p_in), .dout(p_d));
    bpp_delay #(.WIDTH(3*WORD_W), .DEPTH(ST_T-2)) u_dly_vm0 (
        .clk(clk), .en(en), .din(vm_reg), .dout(vm_d66));
    bpp_delay #(.WIDTH(3*WORD_W), .DEPTH(1)) u_dly_vm1 (
        .clk(clk), .en(en), .din(vm_d66), .dout(vm_d67));
    bpp_delay #(.WIDTH(3*WORD_W), .DEPTH(ST_SS+2-(ST_T+1))) u_dly_vm2 (
        .clk(clk), .en(en), .din(vm_d67), .dout(vm_d103));
    bpp_delay #(.WIDTH(3*WORD_W), .DEPTH(ST_SS+3-1)) u_dly_ke (
        .clk(clk), .en(en), .din(ke_reg), .dout(ke_d));
    bpp_delay #(.WIDTH(3*WORD_W), .DEPTH(ST_SS-ST_T)) u_dly_t (
        .clk(clk), .en(en), .din(t_reg), .dout(t_d));
    bpp_delay #(.WIDTH(3*WORD_W), .DEPTH(ST_SS+1-ST_DEN)) u_dly_v0 (
        .clk(clk), .en(en), .din(v0_reg), .dout(v0_d));
    bpp_delay #(.WIDTH(WORD_W), .DEPTH(ST_SS+4-ST_TS)) u_dly_h (
        .clk(clk), .en(en), .din(hscale), .dout(h_d));
    bpp_delay #(.WIDTH(WORD_W), .DEPTH(ST_OUT-1-ST_G)) u_dly_g (
        .clk(clk), .en(en), .din(gamma), .dout(gamma_d));
    bpp_delay #(.WIDTH(3*WORD_W), .DEPTH(1)) u_dly_nv (
        .clk(clk), .en(en), .din(nv_reg), .dout(nv_d));

    bpp_sqrt u_sqrt (
        .clk(clk), .en(en), .x(g2_reg), .root(gamma));

    bpp_div u_div_t (
        .clk(clk), .en(en), .num(kcoef_reg), .den(gamma), .quo(tscale));
    bpp_div u_div_h (
        .clk(clk), .en(en), .num(word_t'({1'b0, tstep_reg})), .den(gamma), .quo(hscale));
    bpp_div u_div_s (
        .clk(clk), .en(en), .num(FX_TWO), .den(den_reg), .quo(sscale));

    always_comb
    begin
        int j;
        int m;
        sq_next  = clamp_pos({2'b00, uu_reg[0]} + {2'b00, uu_reg[1]} + {2'b00, uu_reg[2]});
        m_next   = fx_mul(sq_reg, word_t'({1'b0, inv_c2_reg}));
        g2_next  = clamp_pos({2'b00, FX_ONE} + {2'b00, m_reg});
        den_next = clamp_pos({2'b00, FX_ONE} + {2'b00, tt_reg[0]} + {2'b00, tt_reg[1]}
                             + {2'b00, tt_reg[2]});
        for (int i = 0; i < 3; i++)
        begin
            j = (i == 2) ? 0 : i + 1;
            m = (i == 0) ? 2 : i - 1;
            uu_next[i] = fx_mul(u_in[i], u_in[i]);
            ke_next[i] = fx_mul(kcoef_reg, e_in[i]);
            vm_next[i] = sat_add(u_d1[i], ke_reg[i]);
            t_next[i]  = fx_mul(tscale, b_d[i]);
            tt_next[i] = fx_mul(t_reg[i], t_reg[i]);
            cp_next[i] = fx_mul(vm_d66[j], t_reg[m]);
            cq_next[i] = fx_mul(vm_d66[m], t_reg[j]);
            v0_next[i] = sat_add(vm_d67[i], sat_sub(cp_reg[i], cq_reg[i]));
            s_next[i]  = fx_mul(sscale, t_d[i]);
            p2_next[i] = fx_mul(v0_d[j], s_reg[m]);
            q2_next[i] = fx_mul(v0_d[m], s_reg[j]);
            vp_next[i] = sat_add(vm_d103[i], sat_sub(p2_reg[i], q2_reg[i]));
            nv_next[i] = sat_add(vp_reg[i], ke_d[i]);
            hn_next[i] = fx_mul(h_d, nv_reg[i]);
            np_next[i] = sat_add(p_d[i], hn_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            uu_reg   <= uu_next;
            ke_reg   <= ke_next;
            sq_reg   <= sq_next;
            vm_reg   <= vm_next;
            m_reg    <= m_next;
            g2_reg   <= g2_next;
            t_reg    <= t_next;
            tt_reg   <= tt_next;
            cp_reg   <= cp_next;
            cq_reg   <= cq_next;
            den_reg  <= den_next;
            v0_reg   <= v0_next;
            s_reg    <= s_next;
            p2_reg   <= p2_next;
            q2_reg   <= q2_next;
            vp_reg   <= vp_next;
            nv_reg   <= nv_next;
            hn_reg   <= hn_next;
            np_reg   <= np_next;
            nvo_reg  <= nv_d;
            gout_reg <= gamma_d;
        end
    end

    assign m_tdata = {{(OUT_W-6*WORD_W-GAMMA_W){1'b0}}, gout_reg[GAMMA_W-1:0],
                      np_reg[2], np_reg[1], np_reg[0], nvo_reg[2], nvo_reg[1], nvo_reg[0]};

endmodule

// ===== rtl/core/bpp_checker.sv =====
// Port-level checker for the relativistic Boris particle push core, bound to the top level.
// Depends on bpp_pkg.
module bpp_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [bpp_pkg::OUT_W-1:0]  m_tdata
);
    import bpp_pkg::*;

    logic [GAMMA_W-1:0] gamma_out;

    assign gamma_out = m_tdata[6*WORD_W +: GAMMA_W];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result transaction dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

    a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while the pipeline is stalled");

    a_gamma_min: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> gamma_out >= GAMMA_W'(FX_ONE))
        else $error("lorentz factor below one");

endmodule

bind relativistic_boris_particle_push_core bpp_checker u_bpp_checker (
    .clk(clk),
    .rst_n(rst_n),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
);

// ===== bench/tb.sv =====
// Testbench for relativistic_boris_particle_push_core: streams particles with random gaps and output
// stalls, and checks results against a bit-exact fixed-point Boris push predictor or typed values.
// Depends on bpp_pkg and the core RTL.
`timescale 1ns / 100ps

module tb;
    import bpp_pkg::*;

    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;
    localparam int N_RANDOM = 1326;
    localparam logic [ADDR_W-1:0] CFG_SPARE = 2'd3;

    typedef struct {
        logic signed [31:0] vel[3];
        logic signed [31:0] ef[3];
        logic signed [31:0] bf[3];
        logic signed [31:0] pos[3];
    } particle_t;

    typedef struct {
        logic signed [31:0] nvel[3];
        logic signed [31:0] npos[3];
        logic [30:0]        gamma;
    } push_res_t;

    typedef struct {
        particle_t p;
        logic      typed;
        push_res_t r;
    } row_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [ADDR_W-1:0] cfg_addr;
    logic [WORD_W-1:0] cfg_wdata;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;

    longint    kick_q;
    longint    invc2_q;
    longint    step_q;
    push_res_t pending_pushes[$];
    int        n_fail;
    int        n_sent;
    int        n_seen;
    int        n_cfg;
    bit        rx_on;

    relativistic_boris_particle_push_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic longint clampw(longint a);
        if (a > WMAX)
        begin
            return WMAX;
        end
        if (a < WMIN)
        begin
            return WMIN;
        end
        return a;
    endfunction

    function automatic longint signed_mag(bit neg, longint q);
        return neg ? clampw(-q) : clampw(q);
    endfunction

    function automatic longint q_mul(longint a, longint b);
        longint ma;
        longint mb;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        return signed_mag((a < 0) != (b < 0), (ma * mb) >>> FRAC_W);
    endfunction

    function automatic longint q_div(longint a, longint b);
        longint ma;
        if (b <= 0)
        begin
            return 0;
        end
        ma = (a < 0) ? -a : a;
        return signed_mag(a < 0, (ma <<< FRAC_W) / b);
    endfunction

    function automatic longint q_sqrt(longint x);
        longint t;
        longint r;
        longint c;
        t = (x < 0) ? 0 : (x <<< FRAC_W);
        r = 0;
        for (int bt = 29; bt >= 0; bt--)
        begin
            c = r | (64'sd1 <<< bt);
            if (c * c <= t)
            begin
                r = c;
            end
        end
        return clampw(r);
    endfunction

    function automatic push_res_t boris_push(particle_t p);
        push_res_t res;
        longint u[3], e[3], b[3], t[3], s[3], ke[3], vm[3], v0[3], nv[3];
        longint one, two, sq, gamma, tscale, den, sscale, h, vp;
        int j, m;
        one = 64'sd1 <<< FRAC_W;
        two = 64'sd2 <<< FRAC_W;
        for (int i = 0; i < 3; i++)
        begin
            u[i] = longint'(p.vel[i]);
            e[i] = longint'(p.ef[i]);
            b[i] = longint'(p.bf[i]);
        end
        sq = 0;
        for (int i = 0; i < 3; i++)
        begin
            sq = clampw(sq + q_mul(u[i], u[i]));
        end
        gamma = q_sqrt(clampw(one + q_mul(sq, invc2_q)));
        tscale = q_div(kick_q, gamma);
        den = one;
        for (int i = 0; i < 3; i++)
        begin
            t[i] = q_mul(tscale, b[i]);
            den = clampw(den + q_mul(t[i], t[i]));
        end
        sscale = q_div(two, den);
        for (int i = 0; i < 3; i++)
        begin
            s[i] = q_mul(sscale, t[i]);
            ke[i] = q_mul(kick_q, e[i]);
            vm[i] = clampw(u[i] + ke[i]);
        end
        for (int i = 0; i < 3; i++)
        begin
            j = (i + 1) % 3;
            m = (i + 2) % 3;
            v0[i] = clampw(vm[i] + clampw(q_mul(vm[j], t[m]) - q_mul(vm[m], t[j])));
        end
        for (int i = 0; i < 3; i++)
        begin
            j = (i + 1) % 3;
            m = (i + 2) % 3;
            vp = clampw(vm[i] + clampw(q_mul(v0[j], s[m]) - q_mul(v0[m], s[j])));
            nv[i] = clampw(vp + ke[i]);
        end
        h = q_div(step_q, gamma);
        for (int i = 0; i < 3; i++)
        begin
            res.nvel[i] = nv[i][31:0];
            res.npos[i] = 32'(clampw(longint'(p.pos[i]) + q_mul(h, nv[i])));
        end
        res.gamma = gamma[30:0];
        return res;
    endfunction

    function automatic logic [IN_W-1:0] pack_particle(particle_t p);
        logic [IN_W-1:0] d;
        for (int i = 0; i < 3; i++)
        begin
            d[32*i +: 32]       = p.vel[i];
            d[32*(3+i) +: 32]   = p.ef[i];
            d[32*(6+i) +: 32]   = p.bf[i];
            d[32*(9+i) +: 32]   = p.pos[i];
        end
        return d;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
            2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            3: return 32'($signed($urandom_range(0, 32'h0000_2000)) - 32'sh0000_1000);
            default: return 32'($signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000);
        endcase
    endfunction

    function automatic particle_t rand_particle();
        particle_t p;
        for (int i = 0; i < 3; i++)
        begin
            p.vel[i] = rand_word();
            p.ef[i]  = rand_word();
            p.bf[i]  = rand_word();
            p.pos[i] = rand_word();
        end
        return p;
    endfunction

    function automatic particle_t flat_particle(logic [31:0] v, logic [31:0] f, logic [31:0] x);
        particle_t p;
        for (int i = 0; i < 3; i++)
        begin
            p.vel[i] = v;
            p.ef[i]  = f;
            p.bf[i]  = f;
            p.pos[i] = x;
        end
        return p;
    endfunction

    task automatic write_reg(logic [ADDR_W-1:0] idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        if (idx == CFG_HALF_KICK)
        begin
            kick_q = longint'($signed(val));
        end
        else if (idx == CFG_INV_C2)
        begin
            invc2_q = longint'(val[30:0]);
        end
        else if (idx == CFG_TIME_STEP)
        begin
            step_q = longint'(val[30:0]);
        end
        n_cfg++;
    endtask

    task automatic set_config(logic [31:0] kick, logic [31:0] invc2, logic [31:0] dt);
        write_reg(CFG_HALF_KICK, kick);
        write_reg(CFG_INV_C2, invc2);
        write_reg(CFG_TIME_STEP, dt);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_particle(particle_t p, bit typed, push_res_t typed_res);
        int gap;
        gap = $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= pack_particle(p);
        s_tvalid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        pending_pushes.push_back(typed ? typed_res : boris_push(p));
        n_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_pushes.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic check_field(string name, longint exp_v, longint got_v);
        if (exp_v != got_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
            n_fail++;
        end
    endtask

    initial
    begin
        int stall;
        push_res_t want;
        m_tready = 1'b0;
        wait (rx_on);
        forever
        begin
            stall = $urandom_range(0, 5);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!m_tvalid);
            n_seen++;
            if (pending_pushes.size() == 0)
            begin
                $error("result transaction with no particle outstanding");
                n_fail++;
            end
            else
            begin
                want = pending_pushes.pop_front();
                for (int i = 0; i < 3; i++)
                begin
                    check_field($sformatf("new_vel[%0d]", i), want.nvel[i],
                                $signed(m_tdata[32*i +: 32]));
                    check_field($sformatf("new_pos[%0d]", i), want.npos[i],
                                $signed(m_tdata[32*(3+i) +: 32]));
                end
                check_field("lorentz_factor", want.gamma, m_tdata[192 +: 31]);
            end
        end
    end

    initial
    begin
        #2ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        row_t rows[12];
        push_res_t rest;
        logic [31:0] kicks[6];
        logic [31:0] invs[6];
        logic [31:0] steps[6];

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        n_fail    = 0;
        n_sent    = 0;
        n_seen    = 0;
        n_cfg     = 0;
        rx_on     = 1'b0;
        kick_q    = 0;
        invc2_q   = 64'sd1 <<< FRAC_W;
        step_q    = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        rx_on = 1'b1;

        // At reset the kick and the time step are zero, so a particle at rest keeps its
        // velocity and position and has a Lorentz factor of exactly one.
        rows[0]  = '{flat_particle(32'h0, 32'h0, 32'h0), 1'b1, rest};
        rows[1]  = '{flat_particle(32'h0, 32'h7fff_ffff, 32'h7fff_ffff), 1'b1, rest};
        rows[2]  = '{flat_particle(32'h0, 32'h8000_0000, 32'h8000_0000), 1'b1, rest};
        rows[3]  = '{flat_particle(32'h7fff_ffff, 32'h7fff_ffff, 32'h0), 1'b0, rest};
        rows[4]  = '{flat_particle(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff), 1'b0, rest};
        rows[5]  = '{flat_particle(32'h0100_0000, 32'h0100_0000, 32'h0100_0000), 1'b0, rest};
        rows[6]  = '{flat_particle(32'hff00_0000, 32'h0080_0000, 32'hff00_0000), 1'b0, rest};
        rows[7]  = '{flat_particle(32'h0000_0001, 32'hffff_ffff, 32'h0000_0001), 1'b0, rest};
        rows[8]  = '{flat_particle(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555), 1'b0, rest};
        rows[9]  = '{flat_particle(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa), 1'b0, rest};
        rows[10] = '{rand_particle(), 1'b0, rest};
        rows[11] = '{rand_particle(), 1'b0, rest};
        for (int r = 0; r < 3; r++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rows[r].r.nvel[i] = 32'h0;
                rows[r].r.npos[i] = rows[r].p.pos[i];
            end
            rows[r].r.gamma = 31'h0100_0000;
        end

        for (int r = 0; r < 12; r++)
        begin
            send_particle(rows[r].p, rows[r].typed, rows[r].r);
        end
        drain();

        set_config(32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff);
        write_reg(CFG_SPARE, 32'h1234_5678);
        cfg_we <= 1'b0;
        for (int r = 0; r < 12; r++)
        begin
            send_particle(rows[r].p, 1'b0, rest);
        end
        drain();

        kicks = '{32'h8000_0000, 32'h0010_0000, 32'hfff0_0000, 32'h0000_0000, 32'h0100_0000, 0};
        invs  = '{32'h0000_0000, 32'h0001_0000, 32'h0100_0000, 32'h7fff_ffff, 32'h8000_0001, 0};
        steps = '{32'h7fff_ffff, 32'h0004_0000, 32'h0000_0000, 32'h0100_0000, 32'h8000_0000, 0};
        kicks[5] = $urandom();
        invs[5]  = $urandom();
        steps[5] = $urandom();
        for (int ph = 0; ph < 6; ph++)
        begin
            set_config(kicks[ph], invs[ph], steps[ph]);
            for (int n = 0; n < N_RANDOM / 6; n++)
            begin
                send_particle(rand_particle(), 1'b0, rest);
            end
            drain();
        end

        repeat (200) @(posedge clk);
        $display("Pushed %0d particles over 8 register settings (%0d writes), %0d results seen.",
                 n_sent, n_cfg, n_seen);
        if (n_fail == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
